// ===== rtl/rsaa_pkg.sv =====
// Package for the row scatter-add accumulator.
// Holds the transaction payload structs, operation codes and controller state encoding.
// No dependencies.
package rsaa_pkg;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpAccum = 2'd1,
    OpRead  = 2'd2,
    OpNop   = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic RegRowLength = 1'b0;

  localparam int RowLenW = 13;
  localparam logic [RowLenW-1:0] MaxRowLength = 13'd4096;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StAddr = 4'b0010,
    StRead = 4'b0100,
    StCalc = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [11:0]        row;
    logic [11:0]        column;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               out_of_range;
    logic               row_done;
    logic               saturated;
  } out_item_t;

endpackage

// ===== rtl/row_scatter_add_accumulator_top.sv =====
// One transaction is in flight at a time: the input stalls from acceptance until the
// result is registered at the output, which an output stall can hold off. Each passes the
// address multiply state, the registered read of the accumulator memory and the modify and
// write back, in that order. Reset clears the controller, the column counter and
// sets row_length to 1; the accumulator memory is not cleared and holds garbage until loaded.
// Top level of the row scatter-add accumulator: APB register, controller and memory.
// Depends on rsaa_pkg.
module row_scatter_add_accumulator_top
  import rsaa_pkg::*;
#(
  parameter int STORE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  localparam int AddrW = $clog2(STORE_DEPTH);
  localparam int FullW = 25;
  localparam logic [FullW-1:0] DepthLim = FullW'(STORE_DEPTH);

  logic [RowLenW-1:0] row_length_q;
  logic [RowLenW-1:0] eff_len;
  logic [11:0]        col_cnt_q, col_cnt_d;
  state_e             state_q, state_d;

  logic [1:0]         op_q;
  logic [11:0]        row_q;
  logic [11:0]        col_q;
  logic [31:0]        val_q;
  logic               done_q;
  logic [FullW-1:0]   addr_q;
  logic               oor_q;

  logic [31:0]        store_q [STORE_DEPTH];
  logic [31:0]        rd_data_q;

  out_item_t          out_q, out_d;
  logic               out_valid_q;

  logic               cfg_wr;
  logic               in_acc;
  logic               advance;
  logic               mem_we;
  logic [12:0]        cnt_inc;
  logic [32:0]        sum;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegRowLength);
  assign prdata = (paddr[2] == RegRowLength) ? {19'b0, row_length_q} : 32'b0;

  always_comb begin
    if (row_length_q == '0) begin
      eff_len = RowLenW'(1);
    end else if (row_length_q > MaxRowLength) begin
      eff_len = MaxRowLength;
    end else begin
      eff_len = row_length_q;
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign advance    = (state_q == StCalc) && (!out_valid_q || !out_stall_i);

  // The column counter advances at acceptance of an accumulate transaction.
  assign cnt_inc = {1'b0, col_cnt_q} + 13'd1;

  always_comb begin
    col_cnt_d = col_cnt_q;
    if (cfg_wr) begin
      col_cnt_d = '0;
    end else if (in_acc && (in_data_i.operation == OpAccum)) begin
      if (cnt_inc >= eff_len) begin
        col_cnt_d = '0;
      end else begin
        col_cnt_d = cnt_inc[11:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_acc) state_d = StAddr;
      StAddr: state_d = StRead;
      StRead: state_d = StCalc;
      StCalc: if (advance) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= RowLenW'(1);
      col_cnt_q    <= '0;
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        row_length_q <= pwdata[RowLenW-1:0];
      end
      col_cnt_q <= col_cnt_d;
      state_q   <= state_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers of the transaction in flight.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= in_data_i.operation;
      row_q  <= in_data_i.row;
      col_q  <= (in_data_i.operation == OpAccum) ? col_cnt_q : in_data_i.column;
      val_q  <= in_data_i.value;
      done_q <= (cnt_inc >= eff_len);
    end
    if (state_q == StAddr) begin
      addr_q <= FullW'(row_q) * FullW'(eff_len) + FullW'(col_q);
    end
    if (state_q == StRead) begin
      oor_q <= (addr_q >= DepthLim);
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Accumulator memory: one read port with registered data, one write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[addr_q[AddrW-1:0]] <= out_d.read_value;
    end
    if (state_q == StRead) begin
      rd_data_q <= store_q[addr_q[AddrW-1:0]];
    end
  end

  assign sum = {rd_data_q[31], rd_data_q} + {val_q[31], val_q};

  always_comb begin
    out_d  = '0;
    mem_we = 1'b0;
    case (op_q)
      OpLoad: begin
        out_d.out_of_range = oor_q;
        if (!oor_q) begin
          out_d.read_value = val_q;
          mem_we           = advance;
        end
      end
      OpRead: begin
        out_d.out_of_range = oor_q;
        if (!oor_q) begin
          out_d.read_value = rd_data_q;
        end
      end
      OpAccum: begin
        out_d.out_of_range = oor_q;
        out_d.row_done     = done_q;
        if (!oor_q) begin
          mem_we = advance;
          // Overflow shows as a mismatch between the two top bits of the wide sum.
          if (sum[32] != sum[31]) begin
            out_d.saturated  = 1'b1;
            out_d.read_value = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            out_d.read_value = sum[31:0];
          end
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/rsaa_checker.sv =====
// Port-level checker for the row scatter-add accumulator, bound to the top level.
// Depends on rsaa_pkg and row_scatter_add_accumulator_top.
module rsaa_checker
  import rsaa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_data_o
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // One transaction in flight: an accepted transaction closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a transaction is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.out_of_range && out_data_o.saturated))
    else $error("out-of-range result marked saturated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_of_range |-> out_data_o.read_value == 32'sd0)
    else $error("out-of-range result carries a value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      (out_data_o.read_value == 32'h7FFF_FFFF) || (out_data_o.read_value == 32'h8000_0000))
    else $error("saturated result is not a limit");

endmodule

bind row_scatter_add_accumulator_top rsaa_checker u_rsaa_checker (.*);
